// File: hdl/prbtf_pkg.sv
// ----------------------------------------------------------------------------
// prbtf_pkg
// Shared types, constants and helper functions of the register bank framer.
// ----------------------------------------------------------------------------
`default_nettype none

package prbtf_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int BANK_DEPTH  = 256;
	localparam int ADDR_W      = $clog2(BANK_DEPTH);
	localparam int IDX_W       = 6;

	// Number of bank bytes the frame needs, gathered before it is built.
	localparam int GATHER_N = 24;
	localparam int GATHER_W = $clog2(GATHER_N);

	localparam logic [ADDR_W-1:0] MODE_REG = 8'h50;
	localparam logic [7:0]        MODE_KEY = 8'hA5;
	localparam logic [15:0]       CRC_POLY = 16'h1021;
	localparam logic [15:0]       CRC_INIT = 16'hFFFF;
	localparam logic [16:0]       DIV_TEN  = 17'd10;
	localparam logic [16:0]       DIV_PWR  = 17'd100000;

	// Reciprocals for division by a constant: q = (x * M) >> SH.
	// The ten form is exact for 16-bit dividends, the power form for 31-bit ones.
	localparam logic [31:0]       RECIP_TEN    = 32'd52429;
	localparam int                RECIP_TEN_SH = 19;
	localparam logic [31:0]       RECIP_PWR    = 32'd2814749768;
	localparam int                RECIP_PWR_SH = 48;

	typedef enum logic [1:0] {
		OP_ADDR_MATCH = 2'd0,
		OP_BUS_DATA   = 2'd1,
		OP_HOST_WRITE = 2'd2,
		OP_REPORT     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATHER,
		ST_DRAIN,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	// Divider job codes.
	typedef enum logic [2:0] {
		JOB_VBAT = 3'd0,
		JOB_IBAT = 3'd1,
		JOB_PWR  = 3'd2,
		JOB_T2D  = 3'd3,
		JOB_T2F  = 3'd4
	} job_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	// Bytes 0x60-0x63, 0x70-0x73 and 0x80-0x81 need the mode key.
	function automatic logic is_guarded(input logic [ADDR_W-1:0] a);
		return (a >= 8'h60 && a <= 8'h63) || (a >= 8'h70 && a <= 8'h73) ||
		       (a >= 8'h80 && a <= 8'h81);
	endfunction

	// Bank address of each gathered byte.
	function automatic logic [ADDR_W-1:0] gather_addr(input logic [GATHER_W-1:0] i);
		logic [ADDR_W-1:0] a;
		a = '0;
		if (i <= 5'd16) begin
			a = ADDR_W'(i);
		end else if (i == 5'd17) begin
			a = 8'h17;
		end else if (i <= 5'd21) begin
			a = 8'h2D + ADDR_W'(i - 5'd18);
		end else if (i == 5'd22) begin
			a = 8'h35;
		end else begin
			a = 8'h36;
		end
		return a;
	endfunction

	// One byte of CRC-16, MSB first.
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [7:0] brand_byte(input logic [2:0] i);
		logic [7:0] b;
		unique case (i)
			3'd0: b = 8'h4E;
			3'd1: b = 8'h75;
			3'd2: b = 8'h31;
			3'd3: b = 8'h37;
			3'd4: b = 8'h31;
			3'd5: b = 8'h31;
			default: b = 8'h33;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: hdl/prbtf_channels.sv
// ----------------------------------------------------------------------------
// prbtf channels
// Valid/ready channel interfaces for input items and frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface prbtf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic [7:0] reg_address;

	modport source (output valid, operation, data_byte, reg_address, input ready);
	modport sink   (input valid, operation, data_byte, reg_address, output ready);
endinterface

interface prbtf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [5:0] byte_index;
	logic       last;

	modport source (output valid, frame_byte, byte_index, last, input ready);
	modport sink   (input valid, frame_byte, byte_index, last, output ready);
endinterface

`default_nettype wire

// File: hdl/prbtf_ram.sv
// ----------------------------------------------------------------------------
// prbtf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prbtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/prbtf_div.sv
// ----------------------------------------------------------------------------
// prbtf_div
// Constant divider by ten or 100000 through reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module prbtf_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire prbtf_pkg::div_req_t req,
	output      prbtf_pkg::div_rsp_t rsp
);
	import prbtf_pkg::*;

	logic        go_s1;
	logic        pwr_s1;
	logic [31:0] num_s1;
	logic        done_s2;
	logic        pwr_s2;
	logic [63:0] prod_s2;
	logic [31:0] recip;

	// Reciprocal of the requested divisor.
	assign recip = pwr_s1 ? RECIP_PWR : RECIP_TEN;

	// Start is registered into go_s1 and then into done_s2, which drives done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1   <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			go_s1   <= req.start;
			done_s2 <= go_s1;
		end
	end

	// Capture the operands, then one 32x32 multiply.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_s1 <= req.dividend;
			pwr_s1 <= (req.divisor == DIV_PWR);
		end
		if (go_s1) begin
			prod_s2 <= num_s1 * recip;
			pwr_s2  <= pwr_s1;
		end
	end

	assign rsp.done     = done_s2;
	assign rsp.quotient = pwr_s2 ? {16'd0, prod_s2[RECIP_PWR_SH+15:RECIP_PWR_SH]}
	                             : {16'd0, prod_s2[RECIP_TEN_SH+15:RECIP_TEN_SH]};

endmodule

`default_nettype wire

// File: hdl/protected_register_bank_telemetry_framer_unit.sv
// ----------------------------------------------------------------------------
// protected_register_bank_telemetry_framer_unit
// 256-byte protected register bank with a 64-byte telemetry frame generator.
// ----------------------------------------------------------------------------
// Input items (address match, bus data, host write) are taken while idle, and
// bank writes go straight into the bank RAM; reset clears the bank through
// per-entry valid bits, so no clearing pass is needed. A report request keeps
// the input busy until the last frame byte is loaded: the 24 needed bank bytes
// are read through the single RAM read port, a drain state empties the read
// pipeline, a multiply state multiplies vbat by ibat, five divisions by 10 or
// 100000 run on a shared reciprocal-multiply divider, and the 64 frame bytes
// then leave one per cycle while the output is ready, with the CRC folded in
// as bytes are loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module protected_register_bank_telemetry_framer_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	prbtf_in_if.sink  item,
	prbtf_out_if.source frame
);
	import prbtf_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0]   wp_q;
	logic                expect_q;
	logic [7:0]          seq_q;
	logic [7:0]          seq_frame_q;
	logic                unlock_q;
	logic [BANK_DEPTH-1:0] valid_q;

	logic [GATHER_W-1:0] g_q;
	logic [GATHER_W-1:0] gi_s1;
	logic                pend_s1;
	logic                vld_s1;
	logic [7:0]          cap_q [GATHER_N];

	logic signed [32:0]  prod_q;
	logic [15:0]         h100_q;
	job_t                job_q;
	logic [15:0]         vq_q, iq_q, pq_q, aq_q, bq_q;

	logic [IDX_W-1:0]    idx_q;
	logic [15:0]         crc_q;
	logic                ovalid_q;
	logic [7:0]          obyte_q;
	logic [IDX_W-1:0]    oidx_q;
	logic                olast_q;

	logic                acc;
	op_t                 op;
	logic                wr_req;
	logic [ADDR_W-1:0]   wr_addr;
	logic                we;
	logic                re;
	logic [ADDR_W-1:0]   raddr;
	logic [7:0]          rdata;
	logic                load;
	logic [7:0]          fbyte;
	logic [15:0]         vbat, ibat_u, t2d, t2f, res16;
	logic [31:0]         ib32, pw32;
	logic                neg;
	div_req_t            dreq;
	div_rsp_t            drsp;

	assign acc = item.valid && item.ready;
	assign op  = op_t'(item.operation);
	assign item.ready = (state_q == ST_IDLE);

	// Write path decode.
	always_comb begin
		wr_req  = 1'b0;
		wr_addr = item.reg_address;
		unique case (op)
			OP_BUS_DATA: begin
				wr_req  = !expect_q;
				wr_addr = wp_q;
			end
			OP_HOST_WRITE: wr_req = 1'b1;
			default: wr_req = 1'b0;
		endcase
	end
	assign we = acc && wr_req && (!is_guarded(wr_addr) || unlock_q);

	assign re    = (state_q == ST_GATHER);
	assign raddr = gather_addr(g_q);

	prbtf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (item.data_byte),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Bus pointer, mode key shadow, valid bits and sequence number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			expect_q <= 1'b0;
			seq_q    <= '0;
			unlock_q <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (acc) begin
				unique case (op)
					OP_ADDR_MATCH: begin
						wp_q     <= '0;
						expect_q <= 1'b1;
					end
					OP_BUS_DATA: begin
						if (expect_q) begin
							expect_q <= 1'b0;
							wp_q     <= item.data_byte;
						end else begin
							wp_q <= wp_q + 8'd1;
						end
					end
					OP_REPORT: seq_q <= seq_q + 8'd1;
					default: ;
				endcase
			end
			if (we) begin
				valid_q[wr_addr] <= 1'b1;
				if (wr_addr == MODE_REG) begin
					unlock_q <= (item.data_byte == MODE_KEY);
				end
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (acc && op == OP_REPORT) state_d = ST_GATHER;
			ST_GATHER:   if (g_q == GATHER_W'(GATHER_N - 1)) state_d = ST_DRAIN;
			ST_DRAIN:    state_d = ST_MUL;
			ST_MUL:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (drsp.done) begin
					state_d = (job_q == JOB_T2F) ? ST_EMIT : ST_DIV_GO;
				end
			end
			ST_EMIT:     if (load && idx_q == IDX_W'(FRAME_BYTES - 1)) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Captured field pairs.
	assign vbat   = {cap_q[6], cap_q[5]};
	assign ibat_u = {cap_q[8], cap_q[7]};
	assign t2d    = {cap_q[19], cap_q[18]};
	assign t2f    = {cap_q[21], cap_q[20]};
	assign ib32   = {{16{ibat_u[15]}}, ibat_u};
	assign pw32   = prod_q[31:0];

	// Divider job selection.
	always_comb begin
		dreq.start    = (state_q == ST_DIV_GO);
		dreq.divisor  = DIV_TEN;
		dreq.dividend = {16'd0, vbat};
		neg           = 1'b0;
		unique case (job_q)
			JOB_VBAT: dreq.dividend = {16'd0, vbat};
			JOB_IBAT: begin
				neg           = ibat_u[15];
				dreq.dividend = neg ? (32'd0 - ib32) : ib32;
			end
			JOB_PWR: begin
				neg           = prod_q[32];
				dreq.divisor  = DIV_PWR;
				dreq.dividend = neg ? (32'd0 - pw32) : pw32;
			end
			JOB_T2D: dreq.dividend = {16'd0, t2d};
			JOB_T2F: dreq.dividend = {16'd0, t2f};
			default: dreq.dividend = {16'd0, vbat};
		endcase
		res16 = neg ? (16'd0 - drsp.quotient[15:0]) : drsp.quotient[15:0];
	end

	prbtf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Frame byte for the current index.
	always_comb begin
		fbyte = 8'h00;
		unique case (idx_q)
			6'd0:  fbyte = 8'h05;
			6'd1:  fbyte = 8'hA5;
			6'd2:  fbyte = 8'h5A;
			6'd3:  fbyte = 8'h02;
			6'd4:  fbyte = 8'h01;
			6'd5:  fbyte = seq_frame_q;
			6'd7:  fbyte = 8'd42;
			6'd9:  fbyte = cap_q[0];
			6'd10: fbyte = cap_q[1];
			6'd11: fbyte = cap_q[2];
			6'd12: fbyte = cap_q[3];
			6'd13: fbyte = cap_q[4];
			6'd14: fbyte = vq_q[7:0];
			6'd15: fbyte = vq_q[15:8];
			6'd16: fbyte = iq_q[7:0];
			6'd17: fbyte = iq_q[15:8];
			6'd18: fbyte = pq_q[7:0];
			6'd19: fbyte = pq_q[15:8];
			6'd20: fbyte = cap_q[17];
			6'd21: fbyte = cap_q[11];
			6'd22: fbyte = cap_q[12];
			6'd23: fbyte = cap_q[9];
			6'd24: fbyte = cap_q[10];
			6'd25: fbyte = cap_q[22];
			6'd26: fbyte = cap_q[23];
			6'd27: fbyte = 8'd2;
			6'd28: fbyte = aq_q[7:0];
			6'd29: fbyte = aq_q[15:8];
			6'd30: fbyte = bq_q[7:0];
			6'd31: fbyte = bq_q[15:8];
			6'd32: fbyte = cap_q[13];
			6'd34: fbyte = h100_q[7:0];
			6'd35: fbyte = h100_q[15:8];
			6'd36: fbyte = 8'd1;
			6'd38: fbyte = 8'd1;
			6'd40: fbyte = 8'd1;
			6'd42: fbyte = 8'd3;
			6'd43: fbyte = 8'd7;
			6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50:
				fbyte = brand_byte(3'(idx_q - 6'd44));
			6'd51: fbyte = crc_q[7:0];
			6'd52: fbyte = crc_q[15:8];
			default: fbyte = 8'h00;
		endcase
	end

	assign load = (state_q == ST_EMIT) && (!ovalid_q || frame.ready);

	// Report datapath: gather, multiply, divide, emit.
	always_ff @(posedge clk) begin
		if (acc && op == OP_REPORT) begin
			seq_frame_q <= seq_q;
		end
		gi_s1  <= g_q;
		vld_s1 <= valid_q[raddr];
		if (pend_s1) begin
			cap_q[gi_s1] <= vld_s1 ? rdata : 8'h00;
		end
		if (state_q == ST_MUL) begin
			prod_q <= $signed({1'b0, vbat}) * $signed(ibat_u);
			h100_q <= 16'({cap_q[16], cap_q[15]} * 7'd100);
		end
		if (state_q == ST_DIV_WAIT && drsp.done) begin
			unique case (job_q)
				JOB_VBAT: vq_q <= res16;
				JOB_IBAT: iq_q <= res16;
				JOB_PWR:  pq_q <= res16;
				JOB_T2D:  aq_q <= res16;
				JOB_T2F:  bq_q <= res16;
				default:  bq_q <= res16;
			endcase
		end
		if (load) begin
			obyte_q <= fbyte;
			oidx_q  <= idx_q;
			olast_q <= (idx_q == IDX_W'(FRAME_BYTES - 1));
		end
	end

	// Sequencer counters, CRC and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q      <= '0;
			pend_s1  <= 1'b0;
			job_q    <= JOB_VBAT;
			idx_q    <= '0;
			crc_q    <= CRC_INIT;
			ovalid_q <= 1'b0;
		end else begin
			pend_s1 <= re;
			if (acc && op == OP_REPORT) begin
				g_q   <= '0;
				job_q <= JOB_VBAT;
				idx_q <= '0;
				crc_q <= CRC_INIT;
			end
			if (re) begin
				g_q <= g_q + GATHER_W'(1);
			end
			if (state_q == ST_DIV_WAIT && drsp.done && job_q != JOB_T2F) begin
				job_q <= job_t'(job_q + 3'd1);
			end
			if (load) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q >= 6'd3 && idx_q <= 6'd50) begin
					crc_q <= crc_step(crc_q, fbyte);
				end
				ovalid_q <= 1'b1;
			end else if (frame.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign frame.valid      = ovalid_q;
	assign frame.frame_byte = obyte_q;
	assign frame.byte_index = oidx_q;
	assign frame.last       = olast_q;

endmodule

`default_nettype wire
